>>> src/skp_pkg.sv
`timescale 1ns / 1ps

package skp_pkg;

    localparam int DIM_W  = 13;
    localparam int POS_W  = 12;
    localparam int AREA_W = 25;
    localparam int PROD_W = 2 * DIM_W;
    localparam int MAX_DIM = 4096;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_CAPTURE,
        OP_CLEAR,
        OP_FULL,
        OP_SCAN,
        OP_READ_J,
        OP_SKIP,
        OP_STEP,
        OP_RB_START,
        OP_READ_K,
        OP_EMIT,
        OP_COMMIT,
        OP_LOAD
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECIDE,
        ST_READ_J,
        ST_STEP,
        ST_PICK,
        ST_READ_K,
        ST_EMIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        dp_op_t op;
        logic   rd_k;
    } dp_cmd_t;

    typedef struct packed {
        logic func;
        logic full;
        logic bad;
        logic j_out;
        logic step_end;
        logic i_last;
        logic found;
        logic k_out;
        logic new_pending;
        logic out_busy;
    } dp_status_t;

endpackage

>>> src/skp_ctrl.sv
`timescale 1ns / 1ps

module skp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  skp_pkg::dp_status_t st,
    output skp_pkg::dp_cmd_t    cmd
);
    import skp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.rd_k   = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (st.func)
                begin
                    cmd.op     = OP_CLEAR;
                    state_next = ST_OUT;
                end
                else if (st.full)
                begin
                    cmd.op     = OP_FULL;
                    state_next = ST_OUT;
                end
                else if (st.bad)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.op     = OP_SCAN;
                    state_next = ST_READ_J;
                end
            end
            ST_READ_J:
            begin
                if (st.j_out)
                begin
                    cmd.op     = OP_SKIP;
                    state_next = st.i_last ? ST_PICK : ST_READ_J;
                end
                else
                begin
                    cmd.op     = OP_READ_J;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.op = OP_STEP;
                if (st.step_end && st.i_last)
                begin
                    state_next = ST_PICK;
                end
                else
                begin
                    state_next = ST_READ_J;
                end
            end
            ST_PICK:
            begin
                if (st.found)
                begin
                    cmd.op     = OP_RB_START;
                    state_next = ST_READ_K;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_READ_K:
            begin
                cmd.rd_k = 1'b1;
                if (st.k_out)
                begin
                    cmd.op     = OP_COMMIT;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.op     = OP_READ_K;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.rd_k   = 1'b1;
                cmd.op     = OP_EMIT;
                state_next = st.new_pending ? ST_EMIT : ST_READ_K;
            end
            ST_OUT:
            begin
                if (!st.out_busy)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

>>> src/skp_dp.sv
`timescale 1ns / 1ps

module skp_dp #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  skp_pkg::dp_cmd_t                    cmd,
    output skp_pkg::dp_status_t                 st,
    input  logic                                in_func,
    input  logic [skp_pkg::DIM_W-1:0]           in_w,
    input  logic [skp_pkg::DIM_W-1:0]           in_h,
    input  logic                                cfg_we,
    input  logic                                cfg_sel,
    input  logic [skp_pkg::DIM_W-1:0]           cfg_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [skp_pkg::OUT_TDATA_W-1:0]     out_data
);
    import skp_pkg::*;

    localparam int CW    = $clog2(MAX_SEGMENTS + 1);
    localparam int AW    = $clog2(MAX_SEGMENTS);
    localparam int DEPTH = 2 * MAX_SEGMENTS;
    localparam int PAD_W = OUT_TDATA_W - (2 + 2 * POS_W + AREA_W);

    logic [DIM_W-1:0] mem_x [DEPTH];
    logic [DIM_W-1:0] mem_y [DEPTH];
    logic [DIM_W-1:0] mem_w [DEPTH];

    logic [DIM_W-1:0] rd_x_reg, rd_y_reg, rd_w_reg;
    logic [AW:0]      rd_addr;
    logic             wr_en;
    logic [AW:0]      wr_addr;
    logic [DIM_W-1:0] wr_x, wr_y, wr_w;

    logic             bank_reg;
    logic [CW-1:0]    count_reg, i_reg, j_reg, k_reg, wcnt_reg, best_i_reg;
    logic             first_reg, found_reg, new_done_reg, trim_reg, pend_valid_reg;
    logic [DIM_W-1:0] cy_reg, cand_x_reg, cand_w_reg, best_x_reg, best_y_reg, best_w_reg;
    logic signed [DIM_W+1:0] left_reg;
    logic [DIM_W-1:0] pend_x_reg, pend_y_reg, pend_w_reg;
    logic             func_reg;
    logic [DIM_W-1:0] w_reg, h_reg, aw_reg, ah_reg;
    logic             res_placed_reg, res_full_reg;
    logic [POS_W-1:0] res_x_reg, res_y_reg;
    logic [AREA_W-1:0] area_reg;
    logic             out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [DIM_W-1:0] aw_eff, ah_eff;
    logic [DIM_W-1:0] y_max, cw_now, cx_now;
    logic             x_over, y_over, rej, done, better;
    logic signed [DIM_W+1:0] left_base, left_new;
    logic [CW-1:0]    i_next;
    logic [DIM_W:0]   end_x, d_end;
    logic signed [DIM_W+1:0] nw;
    logic             overl, new_pending;
    logic             e_vld, trim_next, merge;
    logic [DIM_W-1:0] e_x, e_y, e_w;
    logic [PROD_W-1:0] prod;
    logic [AREA_W+1:0] area_sum;

    assign aw_eff = (32'(aw_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : aw_reg;
    assign ah_eff = (32'(ah_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : ah_reg;

    assign rd_addr = cmd.rd_k ? {bank_reg, k_reg[AW-1:0]} : {bank_reg, j_reg[AW-1:0]};

    always_ff @(posedge clk)
    begin
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
        rd_w_reg <= mem_w[rd_addr];
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
            mem_w[wr_addr] <= wr_w;
        end
    end

    assign y_max     = (first_reg || rd_y_reg > cy_reg) ? rd_y_reg : cy_reg;
    assign x_over    = ({1'b0, rd_x_reg} + {1'b0, w_reg}) > {1'b0, aw_eff};
    assign y_over    = ({1'b0, y_max} + {1'b0, h_reg}) > {1'b0, ah_eff};
    assign left_base = first_reg ? $signed({2'b00, w_reg}) : left_reg;
    assign left_new  = left_base - $signed({2'b00, rd_w_reg});
    assign rej       = (first_reg && x_over) || y_over;
    assign done      = !rej && (left_new <= 0);
    assign cw_now    = first_reg ? rd_w_reg : cand_w_reg;
    assign cx_now    = first_reg ? rd_x_reg : cand_x_reg;
    assign better    = !found_reg || (y_max < best_y_reg) ||
                       ((y_max == best_y_reg) && (cw_now < best_w_reg));
    assign i_next    = i_reg + 1'b1;

    assign end_x       = {1'b0, best_x_reg} + {1'b0, w_reg};
    assign d_end       = {1'b0, rd_x_reg} + {1'b0, rd_w_reg};
    assign nw          = $signed({1'b0, d_end}) - $signed({1'b0, end_x});
    assign overl       = {1'b0, rd_x_reg} < end_x;
    assign new_pending = (k_reg == best_i_reg) && !new_done_reg;

    always_comb
    begin
        e_vld     = 1'b1;
        trim_next = 1'b0;
        e_x       = rd_x_reg;
        e_y       = rd_y_reg;
        e_w       = rd_w_reg;
        if (new_pending)
        begin
            e_x       = best_x_reg;
            e_y       = best_y_reg + h_reg;
            e_w       = w_reg;
            trim_next = 1'b1;
        end
        else if (trim_reg && overl)
        begin
            if (nw <= 0)
            begin
                e_vld     = 1'b0;
                trim_next = 1'b1;
            end
            else
            begin
                e_x = end_x[DIM_W-1:0];
                e_w = nw[DIM_W-1:0];
            end
        end
    end

    assign merge = pend_valid_reg && (pend_y_reg == e_y);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {~bank_reg, wcnt_reg[AW-1:0]};
        wr_x    = pend_x_reg;
        wr_y    = pend_y_reg;
        wr_w    = pend_w_reg;
        case (cmd.op)
            OP_INIT, OP_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = {bank_reg, AW'(0)};
                wr_x    = '0;
                wr_y    = '0;
                wr_w    = aw_eff;
            end
            OP_EMIT:
            begin
                wr_en = !new_pending ? (e_vld && pend_valid_reg && !merge)
                                     : (pend_valid_reg && !merge);
            end
            OP_COMMIT:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign prod     = w_reg * h_reg;
    assign area_sum = {2'b00, area_reg} + {1'b0, prod};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg       <= 1'b0;
            count_reg      <= CW'(1);
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            wcnt_reg       <= '0;
            best_i_reg     <= '0;
            first_reg      <= 1'b1;
            found_reg      <= 1'b0;
            new_done_reg   <= 1'b0;
            trim_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            aw_reg         <= DIM_W'(1024);
            ah_reg         <= DIM_W'(1024);
            area_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_sel)
                begin
                    ah_reg <= cfg_value;
                end
                else
                begin
                    aw_reg <= cfg_value;
                end
            end
            if (cmd.op == OP_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_INIT:
                begin
                    count_reg <= CW'(1);
                end
                OP_CLEAR:
                begin
                    count_reg <= CW'(1);
                    area_reg  <= '0;
                end
                OP_SCAN:
                begin
                    i_reg     <= '0;
                    j_reg     <= '0;
                    first_reg <= 1'b1;
                    found_reg <= 1'b0;
                end
                OP_SKIP:
                begin
                    i_reg     <= i_next;
                    j_reg     <= i_next;
                    first_reg <= 1'b1;
                end
                OP_STEP:
                begin
                    if (rej || done)
                    begin
                        if (done && better)
                        begin
                            found_reg  <= 1'b1;
                            best_i_reg <= i_reg;
                        end
                        i_reg     <= i_next;
                        j_reg     <= i_next;
                        first_reg <= 1'b1;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        first_reg <= 1'b0;
                    end
                end
                OP_RB_START:
                begin
                    k_reg          <= '0;
                    wcnt_reg       <= '0;
                    pend_valid_reg <= 1'b0;
                    new_done_reg   <= 1'b0;
                    trim_reg       <= 1'b0;
                end
                OP_EMIT:
                begin
                    trim_reg <= trim_next;
                    if (new_pending)
                    begin
                        new_done_reg <= 1'b1;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    if (e_vld && !merge)
                    begin
                        pend_valid_reg <= 1'b1;
                        if (pend_valid_reg)
                        begin
                            wcnt_reg <= wcnt_reg + 1'b1;
                        end
                    end
                end
                OP_COMMIT:
                begin
                    count_reg <= wcnt_reg + 1'b1;
                    bank_reg  <= ~bank_reg;
                    area_reg  <= (area_sum > {2'b00, AREA_MAX}) ? AREA_MAX
                                                                 : area_sum[AREA_W-1:0];
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                func_reg       <= in_func;
                w_reg          <= in_w;
                h_reg          <= in_h;
                res_placed_reg <= 1'b0;
                res_full_reg   <= 1'b0;
                res_x_reg      <= '0;
                res_y_reg      <= '0;
            end
            OP_FULL:
            begin
                res_full_reg <= 1'b1;
            end
            OP_STEP:
            begin
                if (rej || done)
                begin
                    if (done && better)
                    begin
                        best_x_reg <= cx_now;
                        best_y_reg <= y_max;
                        best_w_reg <= cw_now;
                    end
                end
                else
                begin
                    cy_reg   <= y_max;
                    left_reg <= left_new;
                    if (first_reg)
                    begin
                        cand_x_reg <= rd_x_reg;
                        cand_w_reg <= rd_w_reg;
                    end
                end
            end
            OP_EMIT:
            begin
                if (e_vld)
                begin
                    if (merge)
                    begin
                        pend_w_reg <= pend_w_reg + e_w;
                    end
                    else
                    begin
                        pend_x_reg <= e_x;
                        pend_y_reg <= e_y;
                        pend_w_reg <= e_w;
                    end
                end
            end
            OP_COMMIT:
            begin
                res_placed_reg <= 1'b1;
                res_x_reg      <= best_x_reg[POS_W-1:0];
                res_y_reg      <= best_y_reg[POS_W-1:0];
            end
            OP_LOAD:
            begin
                out_data_reg <= {{PAD_W{1'b0}}, res_full_reg, area_reg, res_y_reg,
                                 res_x_reg, res_placed_reg};
            end
            default:
            begin
                func_reg <= func_reg;
            end
        endcase
    end

    assign st.func        = func_reg;
    assign st.full        = count_reg >= CW'(MAX_SEGMENTS);
    assign st.bad         = (w_reg == '0) || (h_reg == '0) || (w_reg > aw_eff) ||
                            (h_reg > ah_eff);
    assign st.j_out       = j_reg >= count_reg;
    assign st.step_end    = rej || done;
    assign st.i_last      = i_next >= count_reg;
    assign st.found       = found_reg;
    assign st.k_out       = k_reg >= count_reg;
    assign st.new_pending = new_pending;
    assign st.out_busy    = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> src/skyline_rect_packer.sv
`timescale 1ns / 1ps
// Reset request or refused add: decided in ST_DECIDE, then the result beat is loaded.
// Add: a fit scan over the segments on the single table read port, then a rebuild of the
// segments into the other bank. One request in flight; the next is taken once the result
// is registered. Reset: one segment of full width, area zero, table init in ST_INIT.
module skyline_rect_packer #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [skp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // rect_width, rect_height
    input  logic                                s_axis_tuser,  // func
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // placed, pos_x, pos_y, area_total, table_full
    output logic [skp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [skp_pkg::DIM_W-1:0]           cfg_data
);
    import skp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    skp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    skp_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_func   (s_axis_tuser),
        .in_w      (s_axis_tdata[DIM_W-1:0]),
        .in_h      (s_axis_tdata[2*DIM_W-1:DIM_W]),
        .cfg_we    (cfg_valid),
        .cfg_sel   (cfg_index),
        .cfg_value (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

>>> verif/tb_skyline_rect_packer.sv
`timescale 1ns / 1ps

module tb_skyline_rect_packer;

    import skp_pkg::*;

    localparam int MAX_SEGS   = 64;
    localparam int MAX_SIDE   = 4096;
    localparam int IDLE_LIMIT = 60000;
    localparam int ITEM_GOAL  = 1250;

    localparam bit FN_ADD   = 1'b0;
    localparam bit FN_RESET = 1'b1;
    localparam bit REG_WIDTH  = 1'b0;
    localparam bit REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic              placed;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [AREA_W-1:0] area_total;
        logic              table_full;
    } place_res_t;

    typedef struct {
        bit         func;
        int         w;
        int         h;
        bit         typed;
        place_res_t res;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_index;
    logic [DIM_W-1:0]       cfg_data;

    place_res_t   pending_res[$];
    int           errors = 0;
    int           idle_cycles = 0;
    int           out_stall = 0;
    bit           calm = 0;

    logic [DIM_W-1:0] reg_aw = 13'd1024;
    logic [DIM_W-1:0] reg_ah = 13'd1024;
    int seg_x[MAX_SEGS];
    int seg_y[MAX_SEGS];
    int seg_w[MAX_SEGS];
    int seg_cnt = 1;
    int area_sum = 0;

    skyline_rect_packer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int side(logic [DIM_W-1:0] v);
        return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
    endfunction

    function automatic void skyline_reset();
        for (int k = 0; k < MAX_SEGS; k++)
        begin
            seg_x[k] = 0;
            seg_y[k] = 0;
            seg_w[k] = 0;
        end
        seg_w[0] = side(reg_aw);
        seg_cnt  = 1;
        area_sum = 0;
    endfunction

    function automatic void seg_drop(int i);
        for (int k = i; k < seg_cnt - 1; k++)
        begin
            seg_x[k] = seg_x[k+1];
            seg_y[k] = seg_y[k+1];
            seg_w[k] = seg_w[k+1];
        end
        seg_cnt--;
    endfunction

    function automatic place_res_t pack_rect(bit func, int w, int h);
        place_res_t r;
        int aw, ah, bi, by, bw, y, left, j, e, sh, i;
        bit found, ok;
        longint a;
        r = '0;
        aw = side(reg_aw);
        ah = side(reg_ah);
        found = 0;
        bi = 0;
        by = 0;
        bw = 0;
        if (func == FN_RESET)
            skyline_reset();
        else if (seg_cnt >= MAX_SEGS)
            r.table_full = 1'b1;
        else if (w > 0 && h > 0 && w <= aw && h <= ah)
        begin
            for (i = 0; i < seg_cnt; i++)
            begin
                ok = (seg_x[i] + w <= aw);
                y = seg_y[i];
                left = w;
                j = i;
                while (ok && left > 0)
                begin
                    if (j >= seg_cnt)
                        ok = 0;
                    else
                    begin
                        if (seg_y[j] > y)
                            y = seg_y[j];
                        if (y + h > ah)
                            ok = 0;
                        else
                        begin
                            left -= seg_w[j];
                            j++;
                        end
                    end
                end
                if (ok && (!found || y < by || (y == by && seg_w[i] < bw)))
                begin
                    found = 1;
                    bi = i;
                    by = y;
                    bw = seg_w[i];
                end
            end
            if (found)
            begin
                r.placed = 1'b1;
                r.pos_x  = seg_x[bi][POS_W-1:0];
                r.pos_y  = by[POS_W-1:0];
                for (int k = seg_cnt; k > bi; k--)
                begin
                    seg_x[k] = seg_x[k-1];
                    seg_y[k] = seg_y[k-1];
                    seg_w[k] = seg_w[k-1];
                end
                seg_y[bi] = by + h;
                seg_w[bi] = w;
                seg_cnt++;
                i = bi + 1;
                while (i < seg_cnt)
                begin
                    e = seg_x[i-1] + seg_w[i-1];
                    if (seg_x[i] >= e)
                        break;
                    sh = e - seg_x[i];
                    seg_x[i] += sh;
                    seg_w[i] -= sh;
                    if (seg_w[i] > 0)
                        break;
                    seg_drop(i);
                end
                i = 0;
                while (i + 1 < seg_cnt)
                begin
                    if (seg_y[i] == seg_y[i+1])
                    begin
                        seg_w[i] += seg_w[i+1];
                        seg_drop(i + 1);
                    end
                    else
                        i++;
                end
                a = longint'(area_sum) + longint'(w) * longint'(h);
                area_sum = (a > longint'(AREA_MAX)) ? int'(AREA_MAX) : int'(a);
            end
        end
        r.area_total = area_sum[AREA_W-1:0];
        return r;
    endfunction

    task automatic send_rect(bit func, int w, int h, bit typed, place_res_t typed_res);
        int gap;
        place_res_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {6'd0, h[DIM_W-1:0], w[DIM_W-1:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = pack_rect(func, w[DIM_W-1:0], h[DIM_W-1:0]);
        pending_res.push_back(typed ? typed_res : r);
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(bit idx, logic [DIM_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_WIDTH)
            reg_aw = val;
        else
            reg_ah = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_res.size() == 0)
            begin
                $display("%0t unexpected result beat %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                place_res_t x, g;
                x = pending_res.pop_front();
                g.placed     = m_axis_tdata[0];
                g.pos_x      = m_axis_tdata[12:1];
                g.pos_y      = m_axis_tdata[24:13];
                g.area_total = m_axis_tdata[49:25];
                g.table_full = m_axis_tdata[50];
                if (g.placed !== x.placed)
                    $display("%0t placed exp %0d got %0d", $time, x.placed, g.placed);
                if (g.pos_x !== x.pos_x)
                    $display("%0t pos_x exp %0d got %0d", $time, x.pos_x, g.pos_x);
                if (g.pos_y !== x.pos_y)
                    $display("%0t pos_y exp %0d got %0d", $time, x.pos_y, g.pos_y);
                if (g.area_total !== x.area_total)
                    $display("%0t area_total exp %0d got %0d", $time, x.area_total,
                             g.area_total);
                if (g.table_full !== x.table_full)
                    $display("%0t table_full exp %0d got %0d", $time, x.table_full,
                             g.table_full);
                if (g !== x)
                    errors++;
            end
            out_stall = calm ? 0 : $urandom_range(0, 5);
            if (out_stall > 0)
                m_axis_tready <= 1'b0;
        end
        else if (out_stall > 0)
        begin
            out_stall--;
            if (out_stall == 0)
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("FAIL skyline_rect_packer");
                $finish;
            end
        end
    end

    initial
    begin
        dir_row_t rows[14];
        int n, aw, ah, w, h, pick, wait_cnt;
        place_res_t none;
        none = '0;
        rows = '{
            '{FN_RESET, 5, 5, 1, '{1'b0, 12'd0, 12'd0, 25'd0, 1'b0}},
            '{FN_ADD, 1024, 1024, 1, '{1'b1, 12'd0, 12'd0, 25'd1048576, 1'b0}},
            '{FN_ADD, 1, 1, 1, '{1'b0, 12'd0, 12'd0, 25'd1048576, 1'b0}},
            '{FN_RESET, 8191, 8191, 1, '{1'b0, 12'd0, 12'd0, 25'd0, 1'b0}},
            '{FN_ADD, 0, 5, 1, '{1'b0, 12'd0, 12'd0, 25'd0, 1'b0}},
            '{FN_ADD, 5, 0, 1, '{1'b0, 12'd0, 12'd0, 25'd0, 1'b0}},
            '{FN_ADD, 8191, 1, 1, '{1'b0, 12'd0, 12'd0, 25'd0, 1'b0}},
            '{FN_ADD, 1, 8191, 1, '{1'b0, 12'd0, 12'd0, 25'd0, 1'b0}},
            '{FN_ADD, 4096, 1, 1, '{1'b0, 12'd0, 12'd0, 25'd0, 1'b0}},
            '{FN_ADD, 100, 50, 1, '{1'b1, 12'd0, 12'd0, 25'd5000, 1'b0}},
            '{FN_ADD, 200, 10, 1, '{1'b1, 12'd100, 12'd0, 25'd7000, 1'b0}},
            '{FN_ADD, 50, 50, 0, none},
            '{FN_ADD, 724, 974, 0, none},
            '{FN_ADD, 300, 20, 0, none}
        };
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        skyline_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r])
            send_rect(rows[r].func, rows[r].w, rows[r].h, rows[r].typed, rows[r].res);

        n = 0;
        pick = 0;
        while (n < ITEM_GOAL)
        begin
            case (pick)
                0: begin write_reg(REG_WIDTH, 13'd1); write_reg(REG_HEIGHT, 13'd1); end
                1: begin write_reg(REG_WIDTH, 13'd4096); write_reg(REG_HEIGHT, 13'd4096); end
                2: begin write_reg(REG_WIDTH, 13'd8191); write_reg(REG_HEIGHT, 13'd8191); end
                3: begin write_reg(REG_WIDTH, 13'd0); write_reg(REG_HEIGHT, 13'd0); end
                4: begin write_reg(REG_WIDTH, 13'd64); write_reg(REG_HEIGHT, 13'd80); end
                default:
                begin
                    write_reg(REG_WIDTH, ($urandom_range(0, 3) == 0) ?
                              13'($urandom) : 13'($urandom_range(16, 1500)));
                    write_reg(REG_HEIGHT, ($urandom_range(0, 3) == 0) ?
                              13'($urandom) : 13'($urandom_range(16, 1500)));
                end
            endcase
            pick++;
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
            begin
                send_rect(FN_RESET, $urandom_range(0, 8191), $urandom_range(0, 8191), 0, none);
                n++;
            end
            aw = side(reg_aw);
            ah = side(reg_ah);
            for (int k = 0; k < 120 && n < ITEM_GOAL; k++)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    send_rect(FN_RESET, $urandom_range(0, 8191), $urandom_range(0, 8191),
                              0, none);
                    n++;
                end
                else if ($urandom_range(0, 30) == 0 && aw >= 70 && ah >= 70)
                begin
                    send_rect(FN_RESET, 1, 1, 0, none);
                    for (int s = 1; s <= MAX_SEGS + 1; s++)
                        send_rect(FN_ADD, 1, s, 0, none);
                    n += MAX_SEGS + 2;
                end
                else
                begin
                    if ($urandom_range(0, 14) == 0)
                    begin
                        w = $urandom_range(0, 8191);
                        h = $urandom_range(0, 8191);
                    end
                    else
                    begin
                        w = $urandom_range(1, (aw > 3) ? aw / 3 : 1);
                        h = $urandom_range(1, (ah > 3) ? ah / 3 : 1);
                    end
                    send_rect(FN_ADD, w, h, 0, none);
                    n++;
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_cnt = 0;
        while (pending_res.size() != 0 && wait_cnt < IDLE_LIMIT)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_res.size() == 0)
            $display("PASS skyline_rect_packer");
        else
            $display("FAIL skyline_rect_packer");
        $finish;
    end

endmodule

>>> skyline_rect_packer.f
src/skp_pkg.sv
src/skp_ctrl.sv
src/skp_dp.sv
src/skyline_rect_packer.sv
verif/tb_skyline_rect_packer.sv
